### sv/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// mfbp_pkg: shared definitions for the MSB-first bit packer
// Widths, item codes and the command and status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mfbp_pkg;

  // Largest field that one write transfer may append; larger counts saturate.
  localparam int MAX_FIELD_BITS = 32;

  // Fixed widths of the channel fields.
  localparam int FIELD_W   = 32;
  localparam int CNT_W     = 6;
  localparam int BYTE_BITS = 8;

  // Pending bits left over between items: at most one byte minus a bit.
  localparam int PEND_W = BYTE_BITS - 1;
  localparam int PCNT_W = $clog2(BYTE_BITS);

  // Accumulator holds the pending bits followed by one full field.
  localparam int ACC_W  = MAX_FIELD_BITS + PEND_W;
  localparam int TOT_W  = $clog2(ACC_W + 1);
  localparam int SCNT_W = $clog2(MAX_FIELD_BITS + 1);
  localparam int EXT_W  = (ACC_W > FIELD_W) ? ACC_W : FIELD_W;

  // Input item kinds.
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new input item
    logic step;  // one output byte was transferred
  } mfbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;  // the item being loaded produces at least one byte
    logic last;  // the byte on the output is the last of its item
  } mfbp_stat_t;

endpackage

### sv/mfbp_if.sv
// ----------------------------------------------------------------------------
// mfbp_if: valid/ready channels of the MSB-first bit packer
// One interface for the input items and one for the output bytes.
// ----------------------------------------------------------------------------
interface mfbp_in_if
  import mfbp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FIELD_W-1:0] field_value;
  logic [CNT_W-1:0]   bit_count;

  modport source (output valid, output kind, output field_value, output bit_count,
                  input ready);
  modport sink   (input valid, input kind, input field_value, input bit_count,
                  output ready);
endinterface

interface mfbp_out_if
  import mfbp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### sv/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer: MSB-first variable-length bit field packer
// Top level joining the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
// Each append transfer adds the low bit_count bits (saturated to
// MAX_FIELD_BITS) of field_value below the pending bits, and every completed
// byte leaves on the output channel with its first bit in bit 7; last marks
// the final byte of an item. A flush transfer emits the partial byte padded
// with zero low bits and clears the pending bits. An item emits up to four
// bytes, handed out by the single accumulator one byte per cycle while the
// output is ready; no new item is taken until the last byte has left.
module msb_first_bit_packer
  import mfbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mfbp_in_if.sink    in_ch,
  mfbp_out_if.source out_ch
);

  mfbp_cmd_t  cmd;
  mfbp_stat_t stat;

  // Sequencing of input and output transfers.
  mfbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Bit accumulation and byte extraction.
  mfbp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .kind        (in_ch.kind),
    .field_value (in_ch.field_value),
    .bit_count   (in_ch.bit_count),
    .cmd         (cmd),
    .stat        (stat),
    .out_byte    (out_ch.out_byte)
  );

  assign out_ch.last = stat.last;

endmodule

### sv/mfbp_ctrl.sv
// ----------------------------------------------------------------------------
// mfbp_ctrl: controller of the MSB-first bit packer
// Takes one item at a time and sends its bytes one per cycle while out_ready.
// ----------------------------------------------------------------------------
module mfbp_ctrl
  import mfbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mfbp_stat_t stat,
  output mfbp_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.emit) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshake outputs follow the registered state.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

### sv/mfbp_dp.sv
// ----------------------------------------------------------------------------
// mfbp_dp: datapath of the MSB-first bit packer
// Merges a new field below the pending bits and peels bytes off the top.
// ----------------------------------------------------------------------------
module mfbp_dp
  import mfbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 kind,
  input  logic [FIELD_W-1:0]   field_value,
  input  logic [CNT_W-1:0]     bit_count,
  input  mfbp_cmd_t            cmd,
  output mfbp_stat_t           stat,
  output logic [BYTE_BITS-1:0] out_byte
);

  // Bits not yet emitted, right-aligned, and how many of them are valid.
  // Between items total_r is below one byte and its low bits count the
  // pending bits.
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  logic [PCNT_W-1:0]    pcnt;
  logic [PEND_W-1:0]    pend;
  logic [SCNT_W-1:0]    cnt_sat;
  logic [EXT_W-1:0]     val_ext;
  logic [BYTE_BITS-1:0] fl_byte;
  logic [TOT_W-1:0]     sh;

  // Pending bits with stale upper bits masked off.
  assign pcnt = total_r[PCNT_W-1:0];
  assign pend = acc_r[PEND_W-1:0] & ~({PEND_W{1'b1}} << pcnt);

  // Saturate the count and keep only the low bits of the value.
  always_comb begin
    if (bit_count > CNT_W'(MAX_FIELD_BITS)) begin
      cnt_sat = SCNT_W'(MAX_FIELD_BITS);
    end else begin
      cnt_sat = SCNT_W'(bit_count);
    end
  end

  assign val_ext = EXT_W'(field_value) & ~({EXT_W{1'b1}} << cnt_sat);
  assign fl_byte = BYTE_BITS'(pend) << (PCNT_W'(BYTE_BITS - 1) - pcnt + 1'b1);

  // Accumulator contents for the item being offered.
  always_comb begin
    if (kind == KIND_FLUSH) begin
      acc_nxt   = ACC_W'(fl_byte);
      total_nxt = (pcnt != '0) ? TOT_W'(BYTE_BITS) : '0;
    end else begin
      acc_nxt   = (ACC_W'(pend) << cnt_sat) | val_ext[ACC_W-1:0];
      total_nxt = TOT_W'(pcnt) + TOT_W'(cnt_sat);
    end
  end

  assign stat.emit = (total_nxt >= TOT_W'(BYTE_BITS));
  assign stat.last = (total_r < TOT_W'(2 * BYTE_BITS));

  // Current byte sits just above the bits that remain after it.
  assign sh       = total_r - TOT_W'(BYTE_BITS);
  assign out_byte = BYTE_BITS'(acc_r >> sh);

  // Accumulator and bit count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      total_r <= '0;
    end else if (cmd.load) begin
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
    end else if (cmd.step) begin
      total_r <= sh;
    end
  end

endmodule

### verif/msb_first_bit_packer_checker.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_checker: byte stream predictor and scoreboard
// Watches the item and byte channels of the packer, works out the bytes that
// every accepted item must produce and compares each byte transfer, data and
// last flag, with the oldest byte still owed.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_checker
  import mfbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mfbp_in_if   in_mon,
  mfbp_out_if  out_mon,
  output int   error_count,
  output int   bytes_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } packed_byte_t;

  // Bytes owed by the block, oldest first.
  packed_byte_t owed_bytes[$];

  // Our own copy of the partial byte carried between items.
  logic [PEND_W-1:0] held_bits;
  logic [PCNT_W-1:0] held_count;

  initial begin
    error_count       = 0;
    bytes_outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Appends the bytes that one accepted item produces to the owed list and
  // advances the partial byte state.
  task automatic pack_item(input logic kind, input logic [FIELD_W-1:0] value,
                           input logic [CNT_W-1:0] count);
    logic [63:0]  acc;
    int unsigned  used;
    int unsigned  total;
    int unsigned  n_bytes;
    packed_byte_t entry;
    if (kind == KIND_FLUSH) begin
      // A flush pads the partial byte with zero low bits; nothing if empty.
      if (held_count != 0) begin
        acc = 64'(held_bits) << (BYTE_BITS - held_count);
        entry.data = acc[BYTE_BITS-1:0];
        entry.last = 1'b1;
        owed_bytes.push_back(entry);
        held_bits  = '0;
        held_count = '0;
      end
    end else begin
      // Counts beyond the largest field saturate; a zero count is a no-op.
      used = (count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : count;
      if (used != 0) begin
        acc = (64'(held_bits) << used) | (64'(value) & ((64'd1 << used) - 64'd1));
        total   = held_count + used;
        n_bytes = total / BYTE_BITS;
        for (int unsigned i = 0; i < n_bytes; i++) begin
          total     -= BYTE_BITS;
          entry.data = BYTE_BITS'(acc >> total);
          entry.last = (i == n_bytes - 1);
          owed_bytes.push_back(entry);
        end
        held_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
        held_count = PCNT_W'(total);
      end
    end
  endtask

  // Compares one byte transfer with the oldest byte owed.
  task automatic check_byte(input logic [BYTE_BITS-1:0] data, input logic last);
    packed_byte_t want;
    if (owed_bytes.size() == 0) begin
      report_mismatch($sformatf("byte 0x%02h (last %0b) with none owed", data, last));
    end else begin
      want = owed_bytes.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("byte 0x%02h, owed 0x%02h", data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b on byte 0x%02h, owed %0b",
                                  last, want.data, want.last));
    end
  endtask

  // Sample both channels at each rising edge; new items are predicted before
  // the byte of the same edge is checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      owed_bytes.delete();
      held_bits  <= '0;
      held_count <= '0;
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        pack_item(in_mon.kind, in_mon.field_value, in_mon.bit_count);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        check_byte(out_mon.out_byte, out_mon.last);
    end
    bytes_outstanding = owed_bytes.size();
  end

endmodule

### verif/msb_first_bit_packer_test.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_test: top level of the bit packer testbench
// Drives directed and random append and flush items in bursts, stalls the
// byte output on changing patterns with long hold-offs now and then, and
// reports the verdict of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_test
  import mfbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 370;
  localparam int LONG_HOLD    = 64;
  localparam int DRAIN_LIMIT  = 5000;

  // Receiver stall patterns.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_SPARSE  = 3;

  logic clk = 1'b0;
  logic rst_n;
  int   error_count;
  int   bytes_outstanding;
  int   burst_left;

  mfbp_in_if  in_ch ();
  mfbp_out_if out_ch ();

  msb_first_bit_packer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msb_first_bit_packer_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .error_count       (error_count),
    .bytes_outstanding (bytes_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one item and waits for its transfer. Valid stays high into the
  // next item unless the burst ends here, in which case a gap follows.
  task automatic send_item(input logic kind, input logic [FIELD_W-1:0] value,
                           input logic [CNT_W-1:0] count);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.field_value <= value;
    in_ch.bit_count   <= count;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.field_value <= $urandom();
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Receiver: picks its own stall pattern for random stretches and holds
  // off completely for a long stretch now and then to back up the block.
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int cycle_no;
    mode         = RX_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    cycle_no     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no % 1500 == 400) hold_left = LONG_HOLD;
      if (mode_left == 0) begin
        mode      = $urandom_range(RX_ALWAYS, RX_SPARSE);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS:  out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ch.ready <= (cycle_no % 5 != 2) && (cycle_no % 5 != 3);
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic              kind;
    logic [FIELD_W-1:0] value;
    logic [CNT_W-1:0]  count;
    int                sel;
    int                drain_cycles;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_APPEND;
    in_ch.field_value = '0;
    in_ch.bit_count   = '0;
    burst_left        = $urandom_range(1, 40);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush and zero count produce nothing.
    send_item(KIND_FLUSH, 32'h0000_0000, 6'd0);
    send_item(KIND_APPEND, 32'hFFFF_FFFF, 6'd0);
    // A single bit flushed out with seven zero pad bits.
    send_item(KIND_APPEND, 32'h0000_0001, 6'd1);
    send_item(KIND_FLUSH, 32'h0000_0000, 6'd0);
    // Full-width fields of all ones and all zeros.
    send_item(KIND_APPEND, 32'hFFFF_FFFF, 6'd32);
    send_item(KIND_APPEND, 32'h0000_0000, 6'd32);
    // Seven pending bits followed by a full field.
    send_item(KIND_APPEND, 32'h0000_007F, 6'd7);
    send_item(KIND_APPEND, 32'h1234_5678, 6'd32);
    // Oversized counts saturate to the largest field.
    send_item(KIND_APPEND, 32'hA5A5_A5A5, 6'd63);
    send_item(KIND_APPEND, 32'h8000_0001, 6'd33);
    // Bits above the count are dropped.
    send_item(KIND_APPEND, 32'hFFFF_FFF5, 6'd4);
    // Flush ignores its value and count; a second flush finds nothing.
    send_item(KIND_FLUSH, 32'hFFFF_FFFF, 6'd63);
    send_item(KIND_FLUSH, 32'hFFFF_FFFF, 6'd32);
    // Exactly one byte, then a byte built from two short fields.
    send_item(KIND_APPEND, 32'h0000_003C, 6'd8);
    send_item(KIND_APPEND, 32'h0000_0005, 6'd3);
    send_item(KIND_APPEND, 32'h0000_001F, 6'd5);
    // Fields that split across byte boundaries.
    send_item(KIND_APPEND, 32'h7FFF_FFFF, 6'd31);
    send_item(KIND_APPEND, 32'h0000_0001, 6'd1);
    send_item(KIND_APPEND, 32'h8000_0000, 6'd32);
    send_item(KIND_APPEND, 32'h0000_0002, 6'd2);
    send_item(KIND_FLUSH, 32'h0000_0000, 6'd0);

    // Random mix of appends of every size and occasional flushes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind  = ($urandom_range(0, 99) < 15) ? KIND_FLUSH : KIND_APPEND;
      value = $urandom();
      sel   = $urandom_range(0, 99);
      if (sel < 5)       count = '0;
      else if (sel < 12) count = CNT_W'($urandom_range(33, 63));
      else if (sel < 25) count = CNT_W'(MAX_FIELD_BITS);
      else               count = CNT_W'($urandom_range(1, 31));
      send_item(kind, value, count);
    end
    in_ch.valid <= 1'b0;

    // Wait for every owed byte, then let the block settle.
    drain_cycles = 0;
    while (bytes_outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0 && bytes_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
